### rtl/core/error_diffusion_dither_defines.svh
// Assertion macros shared by the error diffusion ditherer RTL.
// Needs clk and arst_n in the scope of each use; no other dependencies.
`ifndef ERROR_DIFFUSION_DITHER_DEFINES_SVH
`define ERROR_DIFFUSION_DITHER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define EDD_ASSERT_IMP(lbl, cond, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

// next-cycle implication, disabled in reset
`define EDD_ASSERT_NXT(lbl, cond, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

### rtl/core/edd_pkg.sv
// Package for the error diffusion ditherer: word types, constants, share math.
// No dependencies.
`default_nettype none

package edd_pkg;

	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 12;

	localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH      = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_THRESHOLD = 4'd1;

	localparam logic [11:0] LINE_WIDTH_RST      = 12'd640;
	localparam logic [7:0]  LEVEL_THRESHOLD_RST = 8'd128;

	localparam logic [8:0] WHITE_LEVEL = 9'd255;

	localparam logic [2:0] K_RIGHT      = 3'd7;
	localparam logic [2:0] K_BELOW_LEFT = 3'd3;
	localparam logic [2:0] K_BELOW      = 3'd5;

	localparam int OUT_DEPTH = 3;

	typedef logic signed [9:0] err_t;

	typedef struct packed {
		logic out_white;
		logic row_end;
	} res_t;

	// store requests of the compute stage toward the line store
	typedef struct packed {
		logic wr_prev;    // store at column - 1
		logic wr_tail;    // end of row: store at column
		logic frame_clr;  // first pixel of a frame
	} store_ctl_t;

	// e * k / 16, truncated toward zero
	function automatic logic signed [7:0] share16(input logic signed [8:0] e,
			input logic [2:0] k);
		logic signed [11:0] ex;
		logic signed [11:0] p;
		logic signed [11:0] q;
		ex = {{3{e[8]}}, e};
		p  = ex * $signed({9'b0, k});
		q  = p[11] ? ((p + 12'sd15) >>> 4) : (p >>> 4);
		return q[7:0];
	endfunction

	function automatic err_t sat10(input logic signed [10:0] v);
		err_t r;
		if (v > 11'sd511)
			r = 10'sd511;
		else if (v < -11'sd512)
			r = -10'sd512;
		else
			r = v[9:0];
		return r;
	endfunction

endpackage

`default_nettype wire

### rtl/core/edd_ifs.sv
// Channel interfaces of the error diffusion ditherer: pixel, result, config.
// Depends on edd_pkg.
`default_nettype none

interface edd_pix_if;
	logic       valid;
	logic       ready;
	logic [7:0] pixel;
	logic       frame_start;

	modport source (output valid, pixel, frame_start, input ready);
	modport sink (input valid, pixel, frame_start, output ready);
endinterface

interface edd_res_if;
	logic valid;
	logic ready;
	logic out_white;
	logic row_end;

	modport source (output valid, out_white, row_end, input ready);
	modport sink (input valid, out_white, row_end, output ready);
endinterface

interface edd_cfg_if;
	import edd_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/core/edd_line_store.sv
// Line store of next-row errors: one-port-write memory, registered read,
// deferred end-of-row write, forwarding and frame fill count. Uses edd_pkg.
`default_nettype none

`include "error_diffusion_dither_defines.svh"

module edd_line_store #(
	parameter int MAX_WIDTH = 2048
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           rd_en,
	input  wire [$clog2(MAX_WIDTH)-1:0]   rd_addr,
	input  wire [$clog2(MAX_WIDTH)-1:0]   col,
	input  edd_pkg::store_ctl_t           ctl,
	input  edd_pkg::err_t                 prev_data,
	input  edd_pkg::err_t                 tail_data,
	output edd_pkg::err_t                 above
);
	import edd_pkg::*;

	localparam int IW = $clog2(MAX_WIDTH);
	localparam int FW = $clog2(MAX_WIDTH + 1);

	err_t mem [MAX_WIDTH];
	err_t rd_q;

	logic          we;
	logic [IW-1:0] wa;
	err_t          wd;

	logic          wr_v_q;
	logic [IW-1:0] wr_a_q;
	err_t          wr_d_q;

	logic          tail_v_q;
	logic [IW-1:0] tail_a_q;
	err_t          tail_d_q;

	logic [FW-1:0] fill_q;
	logic [FW-1:0] fill_base;
	logic [FW-1:0] fill_hi;

	// end-of-row write waits for a free port cycle (next row's column 0)
	always_comb begin
		we = ctl.wr_prev | tail_v_q;
		wa = ctl.wr_prev ? col - IW'(1) : tail_a_q;
		wd = ctl.wr_prev ? prev_data : tail_d_q;
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[wa] <= wd;
		if (rd_en)
			rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_v_q   <= 1'b0;
			tail_v_q <= 1'b0;
			fill_q   <= '0;
		end else begin
			wr_v_q <= we;
			if (ctl.wr_tail)
				tail_v_q <= 1'b1;
			else if (!ctl.wr_prev)
				tail_v_q <= 1'b0;
			fill_q <= (fill_hi > fill_base) ? fill_hi : fill_base;
		end
	end

	always_ff @(posedge clk) begin
		wr_a_q <= wa;
		wr_d_q <= wd;
		if (ctl.wr_tail) begin
			tail_a_q <= col;
			tail_d_q <= tail_data;
		end
	end

	// columns at or past the fill count were not written this frame
	always_comb begin
		fill_base = ctl.frame_clr ? '0 : fill_q;
		if (ctl.wr_tail)
			fill_hi = FW'(col) + FW'(1);
		else if (ctl.wr_prev)
			fill_hi = FW'(col);
		else
			fill_hi = '0;
	end

	always_comb begin
		if (ctl.frame_clr || FW'(col) >= fill_q)
			above = '0;
		else if (tail_v_q && tail_a_q == col)
			above = tail_d_q;
		else if (wr_v_q && wr_a_q == col)
			above = wr_d_q;
		else
			above = rd_q;
	end

	`EDD_ASSERT_IMP(a_tail_drained, ctl.wr_prev, !tail_v_q, "row write while end-of-row write pending")
	`EDD_ASSERT_NXT(a_tail_held, ctl.wr_tail, tail_v_q, "end-of-row write lost")
	`EDD_ASSERT_IMP(a_fill_range, 1'b1, fill_q <= FW'(MAX_WIDTH), "fill count past line length")

endmodule

`default_nettype wire

### rtl/core/edd_diffuse.sv
// Column tracking and the compute stage: correction, threshold,
// error shares and row carries. Uses edd_pkg.
`default_nettype none

module edd_diffuse #(
	parameter int MAX_WIDTH = 2048
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           acc,
	input  wire [7:0]                     pixel,
	input  wire                           frame_start,
	input  wire [11:0]                    line_width,
	input  wire [7:0]                     level_threshold,
	output logic                          rd_en,
	output logic [$clog2(MAX_WIDTH)-1:0]  rd_addr,
	output logic [$clog2(MAX_WIDTH)-1:0]  col_s1,
	output edd_pkg::store_ctl_t           ctl,
	input  edd_pkg::err_t                 above,
	output edd_pkg::err_t                 prev_data,
	output edd_pkg::err_t                 tail_data,
	output logic                          res_valid,
	output edd_pkg::res_t                 res
);
	import edd_pkg::*;

	localparam int IW = $clog2(MAX_WIDTH);
	localparam int FW = $clog2(MAX_WIDTH + 1);
	localparam int LW = (FW > 12) ? FW : 12;

	logic [IW-1:0] col_q;
	logic [IW-1:0] c_acc;
	logic [LW-1:0] last_col;
	logic          last_acc;

	logic          v_s1;
	logic [7:0]    pix_s1;
	logic          fs_s1;
	logic          last_s1;

	logic signed [8:0] right_q;
	err_t              pend_q;
	logic signed [4:0] diag_q;

	logic signed [8:0]  rc;
	err_t               pb;
	logic signed [4:0]  ds;
	logic signed [11:0] sum;
	logic [7:0]         val;
	logic               white;
	logic signed [8:0]  err;
	logic signed [7:0]  s7, s3, s5, s1;
	err_t               pend_new;

	// accept side: column of the incoming pixel, issue line store read
	always_comb begin
		if (line_width == '0)
			last_col = '0;
		else if (LW'(line_width) > LW'(MAX_WIDTH))
			last_col = LW'(MAX_WIDTH - 1);
		else
			last_col = LW'(line_width) - LW'(1);
		c_acc    = frame_start ? '0 : col_q;
		last_acc = LW'(c_acc) >= last_col;
		rd_en    = acc;
		rd_addr  = c_acc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			v_s1  <= 1'b0;
		end else begin
			v_s1 <= acc;
			if (acc)
				col_q <= last_acc ? '0 : c_acc + IW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			pix_s1  <= pixel;
			fs_s1   <= frame_start;
			col_s1  <= c_acc;
			last_s1 <= last_acc;
		end
	end

	// compute stage
	always_comb begin
		rc  = fs_s1 ? '0 : right_q;
		pb  = fs_s1 ? '0 : pend_q;
		ds  = fs_s1 ? '0 : diag_q;
		sum = {4'b0000, pix_s1} + {{2{above[9]}}, above} + {{3{rc[8]}}, rc};
		if (sum < 12'sd0)
			val = 8'd0;
		else if (sum > 12'sd255)
			val = 8'd255;
		else
			val = sum[7:0];
		white = val > level_threshold;
		err   = white ? ({1'b0, val} - WHITE_LEVEL) : {1'b0, val};
		s7    = share16(err, K_RIGHT);
		s3    = share16(err, K_BELOW_LEFT);
		s5    = share16(err, K_BELOW);
		s1    = share16(err, 3'd1);
		prev_data = sat10({pb[9], pb} + {{3{s3[7]}}, s3});
		pend_new  = sat10({{6{ds[4]}}, ds} + {{3{s5[7]}}, s5});
		tail_data = pend_new;

		ctl.wr_prev   = v_s1 && (col_s1 != '0);
		ctl.wr_tail   = v_s1 && last_s1;
		ctl.frame_clr = v_s1 && fs_s1;

		res_valid     = v_s1;
		res.out_white = white;
		res.row_end   = last_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			right_q <= '0;
			pend_q  <= '0;
			diag_q  <= '0;
		end else if (v_s1) begin
			if (last_s1) begin
				right_q <= '0;
				pend_q  <= '0;
				diag_q  <= '0;
			end else begin
				right_q <= {s7[7], s7};
				pend_q  <= pend_new;
				diag_q  <= s1[4:0];
			end
		end
	end

endmodule

`default_nettype wire

### rtl/core/edd_out_queue.sv
// Three-word result queue between the compute stage and the result channel.
// Uses edd_pkg.
`default_nettype none

`include "error_diffusion_dither_defines.svh"

module edd_out_queue (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           push,
	input  edd_pkg::res_t push_word,
	input  wire           pop,
	output logic          head_valid,
	output edd_pkg::res_t head_word,
	output logic [1:0]    cnt
);
	import edd_pkg::*;

	res_t       q [OUT_DEPTH];
	logic [1:0] wptr_q;
	logic [1:0] rptr_q;

	function automatic logic [1:0] bump(input logic [1:0] p);
		return (p == 2'(OUT_DEPTH - 1)) ? 2'd0 : p + 2'd1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt    <= '0;
		end else begin
			if (push)
				wptr_q <= bump(wptr_q);
			if (pop)
				rptr_q <= bump(rptr_q);
			if (push && !pop)
				cnt <= cnt + 2'd1;
			else if (pop && !push)
				cnt <= cnt - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			q[wptr_q] <= push_word;
	end

	assign head_valid = (cnt != 2'd0);
	assign head_word  = q[rptr_q];

	`EDD_ASSERT_IMP(a_no_overflow, push && !pop, cnt < 2'(OUT_DEPTH), "result queue overflow")
	`EDD_ASSERT_NXT(a_cnt_up, push && !pop, cnt == $past(cnt) + 2'd1, "result count did not rise")
	`EDD_ASSERT_NXT(a_cnt_down, pop && !push, cnt == $past(cnt) - 2'd1, "result count did not fall")

endmodule

`default_nettype wire

### rtl/core/error_diffusion_dither.sv
// Top level of the Floyd-Steinberg error diffusion ditherer.
// Depends on edd_pkg, edd_ifs, edd_line_store, edd_diffuse, edd_out_queue.
//
//  port     | dir  | word                         | handshake
//  ---------+------+------------------------------+----------------------
//  pixels   | in   | pixel[7:0], frame_start      | valid/ready
//  results  | out  | out_white, row_end           | valid/ready
//  cfg      | in   | index[3:0], data[11:0]       | valid/ready, ready = 1
//
//  One pixel per cycle while the result channel keeps up; the row carry closes within the compute stage.
//  An accepted pixel is registered for the compute stage; its result word is registered into the result queue.
//  The line store is one memory, one write and one read per cycle; the end-of-row
//  write is parked in a register until a cycle with no other write (such as the next row's column 0) frees the port.
//  Reset: memory content undefined; a fill count makes unwritten columns read as zero,
//  so there is no clearing pass and a frame start does not stall the pixels.
//  pixels.ready drops only when the result queue plus the word in compute fill it.
`default_nettype none

module error_diffusion_dither #(
	parameter int MAX_WIDTH = 2048
) (
	input wire         clk,
	input wire         arst_n,
	edd_pix_if.sink    pixels,
	edd_res_if.source  results,
	edd_cfg_if.sink    cfg
);
	import edd_pkg::*;

	localparam int IW = $clog2(MAX_WIDTH);

	logic [11:0] line_width_q;
	logic [7:0]  level_threshold_q;

	logic          acc;
	logic          rd_en;
	logic [IW-1:0] rd_addr;
	logic [IW-1:0] col_s1;
	store_ctl_t    ctl;
	err_t          above;
	err_t          prev_data;
	err_t          tail_data;
	logic          res_valid;
	res_t          res;
	logic          head_valid;
	res_t          head_word;
	logic [1:0]    q_cnt;
	logic          pop;

	// configuration: always ready; to be written only while idle, which the block itself does not enforce
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q      <= LINE_WIDTH_RST;
			level_threshold_q <= LEVEL_THRESHOLD_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_LINE_WIDTH:      line_width_q      <= cfg.data;
				CFG_LEVEL_THRESHOLD: level_threshold_q <= cfg.data[7:0];
				default: ;
			endcase
		end
	end

	// room for the word in compute and one more
	assign pixels.ready = (3'(q_cnt) + 3'(res_valid)) < 3'(OUT_DEPTH);
	assign acc          = pixels.valid && pixels.ready;

	edd_diffuse #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_diffuse (
		.clk             (clk),
		.arst_n          (arst_n),
		.acc             (acc),
		.pixel           (pixels.pixel),
		.frame_start     (pixels.frame_start),
		.line_width      (line_width_q),
		.level_threshold (level_threshold_q),
		.rd_en           (rd_en),
		.rd_addr         (rd_addr),
		.col_s1          (col_s1),
		.ctl             (ctl),
		.above           (above),
		.prev_data       (prev_data),
		.tail_data       (tail_data),
		.res_valid       (res_valid),
		.res             (res)
	);

	edd_line_store #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_line_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.col       (col_s1),
		.ctl       (ctl),
		.prev_data (prev_data),
		.tail_data (tail_data),
		.above     (above)
	);

	assign pop = head_valid && results.ready;

	edd_out_queue u_out_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (res_valid),
		.push_word  (res),
		.pop        (pop),
		.head_valid (head_valid),
		.head_word  (head_word),
		.cnt        (q_cnt)
	);

	assign results.valid     = head_valid;
	assign results.out_white = head_word.out_white;
	assign results.row_end   = head_word.row_end;

endmodule

`default_nettype wire

### bench/edd_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the error diffusion ditherer: watches the pixel, result and config
// channels, predicts every result word and compares it in order.
// Depends on edd_pkg and the channel interfaces in edd_ifs.
module edd_checker #(
	parameter int MAX_WIDTH = 2048
) (
	input wire clk,
	input wire arst_n,
	edd_pix_if pixels,
	edd_res_if results,
	edd_cfg_if cfg,
	output int unsigned fail_count,
	output int unsigned backlog
);
	import edd_pkg::*;

	localparam int REPORT_MAX = 10;
	// ring of predicted words; the block holds only a few words in flight
	localparam int EXP_DEPTH  = 256;

	logic [11:0] row_len;
	logic [7:0]  white_above;

	// signed error owed to each column of the next row
	int below_err [MAX_WIDTH];
	int carry_right;
	int col;
	int pend_below;
	int diag_keep;

	res_t        expected_bits [EXP_DEPTH];
	int unsigned exp_head;
	int unsigned exp_tail;
	int unsigned fails;

	function automatic int clip(input int v, input int lo, input int hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic void restart_row();
		carry_right = 0;
		col         = 0;
		pend_below  = 0;
		diag_keep   = 0;
	endfunction

	function automatic void clear_frame();
		foreach (below_err[i])
			below_err[i] = 0;
		restart_row();
	endfunction

	// one pixel through the diffusion: returns the word it must produce
	function automatic res_t dither_pixel(input logic [7:0] level, input logic first);
		int   w;
		int   c;
		int   v;
		int   e;
		int   s7;
		int   s3;
		int   s5;
		int   s1;
		res_t r;
		w = int'(row_len);
		if (w == 0)
			w = 1;
		else if (w > MAX_WIDTH)
			w = MAX_WIDTH;
		if (first)
			clear_frame();
		c = col;
		v = clip(int'(level) + below_err[c] + carry_right, 0, 255);
		r.out_white = v > int'(white_above);
		e = r.out_white ? v - 255 : v;
		// integer division truncates toward zero
		s7 = e * 7 / 16;
		s3 = e * 3 / 16;
		s5 = e * 5 / 16;
		s1 = e / 16;
		// a width shrunk mid-row ends the row at once
		r.row_end = c >= w - 1;
		if (c > 0)
			below_err[c - 1] = clip(pend_below + s3, -512, 511);
		pend_below  = clip(diag_keep + s5, -512, 511);
		diag_keep   = s1;
		carry_right = clip(s7, -256, 255);
		if (r.row_end) begin
			below_err[c] = pend_below;
			restart_row();
		end else begin
			col = c + 1;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		res_t got;
		res_t want;
		if (!arst_n) begin
			row_len     = LINE_WIDTH_RST;
			white_above = LEVEL_THRESHOLD_RST;
			clear_frame();
			exp_head = 0;
			exp_tail = 0;
			fails = 0;
			fail_count <= 0;
			backlog    <= 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
				CFG_LINE_WIDTH: begin
					row_len = cfg.data;
				end
				CFG_LEVEL_THRESHOLD: begin
					white_above = cfg.data[7:0];
				end
				default: ;
				endcase
			end
			// outputs before inputs: a word accepted this edge cannot belong to a
			// pixel accepted at the same edge
			if (results.valid && results.ready) begin
				got.out_white = results.out_white;
				got.row_end   = results.row_end;
				if (exp_tail == exp_head) begin
					fails++;
					if (fails <= REPORT_MAX)
						$display("%0t: unexpected result word: white %0b row_end %0b",
							$time, got.out_white, got.row_end);
				end else begin
					want = expected_bits[exp_head % EXP_DEPTH];
					exp_head++;
					if (got.out_white !== want.out_white || got.row_end !== want.row_end) begin
						fails++;
						if (fails <= REPORT_MAX)
							$display({"%0t: result word mismatch: expected white %0b ",
								"row_end %0b, got white %0b row_end %0b"},
								$time, want.out_white, want.row_end,
								got.out_white, got.row_end);
					end
				end
			end
			if (pixels.valid && pixels.ready) begin
				if (exp_tail - exp_head == EXP_DEPTH) begin
					fails++;
					if (fails <= REPORT_MAX)
						$display("%0t: too many result words owed", $time);
					exp_head++;
				end
				expected_bits[exp_tail % EXP_DEPTH] =
					dither_pixel(pixels.pixel, pixels.frame_start);
				exp_tail++;
			end
			fail_count <= fails;
			backlog    <= exp_tail - exp_head;
		end
	end

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps
// Top of the ditherer bench: clock, reset, pixel and config stimulus, result
// back-pressure and the verdict. Depends on edd_pkg, edd_ifs, edd_checker and the RTL.
module testbench;
	import edd_pkg::*;

	localparam int MAX_WIDTH    = 2048;
	localparam int QUIET_LIMIT  = 4000;   // cycles with no word moving on any channel
	localparam int DRAIN_CYCLES = 16;     // settling wait after the last word has come back, before the verdict
	localparam int PHASES       = 22;

	// register indexes the block has no register behind
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = CFG_LEVEL_THRESHOLD + 1'b1;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = '1;

	// traffic shaping of a phase
	typedef enum logic [1:0] {
		PACE_FULL,
		PACE_SRC_GAPS,
		PACE_SINK_STALLS,
		PACE_BOTH
	} pace_t;

	logic        clk;
	logic        arst_n;
	pace_t       pace;
	int unsigned fail_count;
	int unsigned backlog;
	int unsigned quiet;

	edd_pix_if pix();
	edd_res_if res();
	edd_cfg_if cfg();

	error_diffusion_dither #(
		.MAX_WIDTH(MAX_WIDTH)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.pixels (pix),
		.results(res),
		.cfg    (cfg)
	);

	// predicts and compares; reports failures and the words still owed
	edd_checker #(
		.MAX_WIDTH(MAX_WIDTH)
	) scoreboard (
		.clk       (clk),
		.arst_n    (arst_n),
		.pixels    (pix),
		.results   (res),
		.cfg       (cfg),
		.fail_count(fail_count),
		.backlog   (backlog)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic bit roll(input int pct);
		return $urandom_range(99) < pct;
	endfunction

	function automatic bit source_gap();
		return (pace == PACE_SRC_GAPS && roll(61)) || (pace == PACE_BOTH && roll(22));
	endfunction

	// mix of gray levels: plain random, close to the threshold (where the
	// decision flips on the diffused error), and the rails to drive saturation
	function automatic logic [7:0] pick_level(input logic [7:0] thr);
		int r;
		int v;
		r = $urandom_range(99);
		if (r < 50)
			return 8'($urandom_range(255));
		if (r < 75) begin
			v = int'(thr) + int'($urandom_range(8)) - 4;
			if (v < 0)
				v = 0;
			if (v > 255)
				v = 255;
			return 8'(v);
		end
		if (r < 90)
			return roll(50) ? 8'd0 : 8'd255;
		return roll(50) ? 8'($urandom_range(31)) : 8'($urandom_range(255, 224));
	endfunction

	// result back-pressure, re-rolled every cycle
	always @(posedge clk) begin
		if (!arst_n)
			res.ready <= 1'b0;
		else
			res.ready <= !((pace == PACE_SINK_STALLS && roll(61)) ||
				(pace == PACE_BOTH && roll(22)));
	end

	// watchdog: a run that stops moving words is a failure
	always @(posedge clk) begin
		if (!arst_n || (pix.valid && pix.ready) || (res.valid && res.ready) ||
				(cfg.valid && cfg.ready)) begin
			quiet <= 0;
		end else if (quiet == QUIET_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	// one pixel word; returns in the step of the accepting edge with valid still high,
	// so back-to-back words never see valid dropped and raised in one step
	task automatic send_pixel(input logic [7:0] level, input logic first);
		while (source_gap()) begin
			pix.valid <= 1'b0;
			@(posedge clk);
		end
		pix.valid       <= 1'b1;
		pix.pixel       <= level;
		pix.frame_start <= first;
		do @(posedge clk); while (!pix.ready);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= value;
		do @(posedge clk); while (!cfg.ready);
	endtask

	// both registers, junk above the threshold's byte, now and then a write
	// to an index with no register behind it
	task automatic configure(input logic [11:0] width, input logic [7:0] thr);
		write_reg(CFG_LINE_WIDTH, width);
		write_reg(CFG_LEVEL_THRESHOLD, {4'($urandom_range(15)), thr});
		if (roll(25))
			write_reg(CFG_IDX_W'($urandom_range(CFG_UNUSED_HI, CFG_UNUSED_LO)),
				CFG_DATA_W'($urandom));
		cfg.valid <= 1'b0;
	endtask

	// stop sending and wait until every predicted word has come back;
	// the first edge is always waited so the checker has seen the last pixel
	task automatic drain();
		pix.valid <= 1'b0;
		do @(posedge clk); while (backlog != 0);
	endtask

	initial begin
		int          count;
		logic [11:0] width;
		logic [7:0]  thr;
		logic        first;

		pix.valid       <= 1'b0;
		pix.pixel       <= 8'd0;
		pix.frame_start <= 1'b0;
		cfg.valid       <= 1'b0;
		cfg.index       <= CFG_LINE_WIDTH;
		cfg.data        <= '0;
		pace            <= PACE_FULL;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// --- directed part, no idling ---
		// 3-wide rows: rails, values around the default threshold, two rows and the start of a third
		configure(12'd3, 8'd128);
		send_pixel(8'd255, 1'b1);
		send_pixel(8'd0, 1'b0);
		send_pixel(8'd128, 1'b0);
		send_pixel(8'd129, 1'b0);
		send_pixel(8'd127, 1'b0);
		send_pixel(8'd255, 1'b0);
		send_pixel(8'd0, 1'b0);
		send_pixel(8'd255, 1'b0);
		// the third row closes, then a frame start at the row boundary
		send_pixel(8'd200, 1'b0);
		send_pixel(8'd50, 1'b1);
		send_pixel(8'd0, 1'b0);

		// threshold at zero: anything above black turns white
		drain();
		configure(12'd3, 8'd0);
		send_pixel(8'd0, 1'b1);
		send_pixel(8'd1, 1'b0);
		send_pixel(8'd0, 1'b0);

		// threshold at the top: never white; single-pixel rows
		drain();
		configure(12'd1, 8'd255);
		send_pixel(8'd255, 1'b1);
		send_pixel(8'd255, 1'b0);
		send_pixel(8'd254, 1'b0);

		// width zero behaves like one
		drain();
		configure(12'd0, 8'd128);
		send_pixel(8'd100, 1'b0);
		send_pixel(8'd200, 1'b0);

		// width shrunk mid-row: the next pixel closes the row
		drain();
		configure(12'd6, 8'd128);
		send_pixel(8'd90, 1'b1);
		send_pixel(8'd170, 1'b0);
		send_pixel(8'd30, 1'b0);
		send_pixel(8'd220, 1'b0);
		drain();
		configure(12'd2, 8'd128);
		send_pixel(8'd140, 1'b0);
		send_pixel(8'd60, 1'b0);

		// --- random part ---
		// mostly narrow rows so frames hold many rows and the line store is used
		// heavily; a partial row at the widest and one at an oversize width, both cut
		// short by the next phase. Phases don't always open a frame, so settings
		// change mid-row.
		for (int k = 0; k < PHASES; k++) begin
			count = $urandom_range(35, 20);
			case (k)
			3: begin
				width = 12'd1;
			end
			5: begin
				width = 12'd2048;
				count = 90;
			end
			9: begin
				width = 12'd0;
			end
			13: begin
				width = 12'hFFF;
				count = 90;
			end
			default: begin
				width = roll(20) ? 12'($urandom_range(300, 33)) : 12'($urandom_range(32, 2));
			end
			endcase
			case (k % 5)
			1: begin
				thr = 8'd0;
			end
			3: begin
				thr = 8'd255;
			end
			default: begin
				thr = 8'($urandom_range(255));
			end
			endcase

			drain();
			configure(width, thr);
			pace <= pace_t'(k % 4);
			for (int n = 0; n < count; n++) begin
				if (n == 0)
					first = (k == 5) || roll(50);
				else
					first = (k != 5) && ($urandom_range(199) == 0);
				send_pixel(pick_level(thr), first);
			end
		end

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

### error_diffusion_dither.f
+incdir+rtl/core
rtl/core/edd_pkg.sv
rtl/core/edd_ifs.sv
rtl/core/edd_line_store.sv
rtl/core/edd_diffuse.sv
rtl/core/edd_out_queue.sv
rtl/core/error_diffusion_dither.sv
bench/edd_checker.sv
bench/testbench.sv
